FILE: sv/msr_pkg.sv
// Shared types and constants for the multisynth ratio encoder.
// No dependencies; used by every module of the block.
package msr_pkg;

  localparam int DenW  = 20;               // width of b, c, P2, P3
  localparam int IntW  = 12;               // width of integer part a
  localparam int FracShift = 7;            // 128 = 2**7
  localparam int DivW  = DenW + FracShift; // dividend 128*b, quotient width
  localparam int P1W   = 18;

  localparam logic [IntW-1:0] PllAMin = 12'd15;
  localparam logic [IntW-1:0] PllAMax = 12'd90;
  localparam logic [IntW-1:0] OutAMin = 12'd4;
  localparam logic [IntW-1:0] OutAMax = 12'd2048;
  localparam logic [P1W-1:0]  P1Offset = 18'd512;
  localparam logic [DenW-1:0] P2Special = 20'd128;
  localparam logic [3:0]      CtrlBase = 4'hF;

  // operation codes
  localparam logic OpPll = 1'b0;
  localparam logic OpOut = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegRdiv0 = 2'd0;
  localparam logic [1:0] RegRdiv1 = 2'd1;
  localparam logic [1:0] RegRdiv2 = 2'd2;

  // item attributes carried alongside the divider
  typedef struct packed {
    logic            ok;
    logic            op;
    logic            pll;
    logic [1:0]      port;
    logic [IntW-1:0] a;
    logic            bzero;
    logic            special;  // output, c = 1, b != 0
  } meta_t;

  // one slot of the divider chain
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [DivW-1:0] dq;   // dividend bits shifting out, quotient bits in
    logic [DenW-1:0] den;
    meta_t           meta;
  } slot_t;

endpackage

FILE: sv/msr_div_cell.sv
// One restoring-division cell: resolves one quotient bit per transaction.
// Depends on msr_pkg.
module msr_div_cell import msr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  slot_t in_slot,
  output logic  out_valid,
  output slot_t out_slot
);

  logic [DenW:0] trial;
  logic [DenW:0] diff;
  logic          ge;
  slot_t         slot_next;

  always_comb begin
    trial = {in_slot.rem, in_slot.dq[DivW-1]};
    diff  = trial - {1'b0, in_slot.den};
    ge    = trial >= {1'b0, in_slot.den};
    slot_next      = in_slot;
    slot_next.rem  = ge ? diff[DenW-1:0] : trial[DenW-1:0];
    slot_next.dq   = {in_slot.dq[DivW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_slot <= slot_next;
  end

endmodule

FILE: sv/msr_pack.sv
// Output stage: forms P1/P2/P3, merges R divider, packs the register bytes.
// Depends on msr_pkg.
module msr_pack import msr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  slot_t           in_slot,
  input  logic [2:0]      rdiv0,
  input  logic [2:0]      rdiv1,
  input  logic [2:0]      rdiv2,
  output logic            done,
  output logic            accepted,
  output logic [2:0]      target,
  output logic [63:0]     reg_bytes,
  output logic [7:0]      clock_control,
  output logic [P1W-1:0]  p1_value,
  output logic [DenW-1:0] p2_value,
  output logic [DenW-1:0] p3_value
);

  meta_t           m;
  logic [P1W-1:0]  p1;
  logic [DenW-1:0] p2;
  logic [DenW-1:0] p3;
  logic [2:0]      r;
  logic [2:0]      target_next;
  logic [7:0]      ctrl_next;
  logic [63:0]     bytes_next;

  always_comb begin
    m  = in_slot.meta;
    // c = 1 gives q = 128b, so P1 is shared with the special case
    p1 = {m.a[P1W-FracShift-1:0], {FracShift{1'b0}}} + in_slot.dq[P1W-1:0] - P1Offset;
    p2 = m.special ? (in_slot.dq[DenW-1:0] - P2Special) : in_slot.rem;
    p3 = in_slot.den;
    case (m.port)
      RegRdiv0: r = rdiv0;
      RegRdiv1: r = rdiv1;
      default:  r = rdiv2;
    endcase
    if (m.op == OpPll) begin
      r = 3'd0;
    end
    target_next = (m.op == OpOut) ? (3'd2 + {1'b0, m.port}) : {2'b00, m.pll};
    ctrl_next   = (m.op == OpOut) ? {1'b0, m.bzero, m.pll, 1'b0, CtrlBase} : 8'h00;
    bytes_next  = {p3[15:0], 1'b0, r, 2'b00, p1[17:16], p1[15:0],
                   p3[19:16], p2[19:16], p2[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m.ok) begin
      accepted      <= 1'b1;
      target        <= target_next;
      reg_bytes     <= bytes_next;
      clock_control <= ctrl_next;
      p1_value      <= p1;
      p2_value      <= p2;
      p3_value      <= p3;
    end else begin
      accepted      <= 1'b0;
      target        <= 3'd0;
      reg_bytes     <= 64'd0;
      clock_control <= 8'd0;
      p1_value      <= '0;
      p2_value      <= '0;
      p3_value      <= '0;
    end
  end

endmodule

FILE: sv/multisynth_ratio_encoder.sv
// Top level of the multisynth ratio encoder: input check stage, divider
// chain of msr_div_cell, msr_pack output stage. Depends on msr_pkg.
// Result path: the input register loads on the accepting edge, then 27
//   divider cells, one per quotient bit of 128*b/c, then the output
//   register, whose load raises done.
// Throughput: one transaction per cycle; busy is always low.
// Reset (rst, synchronous): clears R divider codes and all valid bits.
module multisynth_ratio_encoder import msr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  // command channel
  input  logic            start,
  output logic            busy,
  input  logic            op,
  input  logic            pll_select,
  input  logic [1:0]      port,
  input  logic [IntW-1:0] integer_part,
  input  logic [DenW-1:0] numerator,
  input  logic [DenW-1:0] denominator,
  // configuration write port
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [2:0]      cfg_data,
  // result channel (one-cycle strobe, cannot be stalled)
  output logic            done,
  output logic            accepted,
  output logic [2:0]      target,
  output logic [63:0]     reg_bytes,
  output logic [7:0]      clock_control,
  output logic [P1W-1:0]  p1_value,
  output logic [DenW-1:0] p2_value,
  output logic [DenW-1:0] p3_value
);

  // Pipeline never stalls, so a command is taken every cycle.
  assign busy = 1'b0;

  // ---------------- R divider registers ----------------
  // Index 3 has no register; such writes are dropped.
  logic [2:0] rdiv0, rdiv1, rdiv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rdiv0 <= 3'd0;
      rdiv1 <= 3'd0;
      rdiv2 <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegRdiv0: rdiv0 <= cfg_data;
        RegRdiv1: rdiv1 <= cfg_data;
        RegRdiv2: rdiv2 <= cfg_data;
        default:  ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  // Range checks and special-case flags are resolved here so the cells
  // only carry them along.
  logic  range_ok;
  slot_t in_next;

  always_comb begin
    if (op == OpPll) begin
      range_ok = (integer_part >= PllAMin) && (integer_part <= PllAMax);
    end else begin
      range_ok = (port <= 2'd2) && (integer_part >= OutAMin) &&
                 (integer_part <= OutAMax);
    end
    in_next.meta.ok      = range_ok && (denominator != '0);
    in_next.meta.op      = op;
    in_next.meta.pll     = pll_select;
    in_next.meta.port    = port;
    in_next.meta.a       = integer_part;
    in_next.meta.bzero   = (numerator == '0);
    // output divider with c = 1 and nonzero b: P2 = 128b - 128
    in_next.meta.special = (op == OpOut) && (numerator != '0) &&
                           (denominator == DenW'(1));
    in_next.rem = '0;
    in_next.dq  = {numerator, {FracShift{1'b0}}};   // dividend 128*b
    in_next.den = denominator;
  end

  // stage[0] is the input register, stage[k+1] the output of cell k
  logic  vld   [0:DivW];
  slot_t stage [0:DivW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage[0] <= in_next;
  end

  // ---------------- divider chain ----------------
  // Each cell shifts in one dividend bit, does one trial subtract of c and
  // shifts one quotient bit in. After DivW cells dq holds floor(128b/c)
  // and rem holds 128b mod c.
  for (genvar k = 0; k < DivW; k++) begin : g_cell
    msr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_slot   (stage[k]),
      .out_valid (vld[k+1]),
      .out_slot  (stage[k+1])
    );
  end

  // ---------------- output stage ----------------
  // The user must change config only while idle; the block does not enforce it. Live R codes are used here.
  msr_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (vld[DivW]),
    .in_slot       (stage[DivW]),
    .rdiv0         (rdiv0),
    .rdiv1         (rdiv1),
    .rdiv2         (rdiv2),
    .done          (done),
    .accepted      (accepted),
    .target        (target),
    .reg_bytes     (reg_bytes),
    .clock_control (clock_control),
    .p1_value      (p1_value),
    .p2_value      (p2_value),
    .p3_value      (p3_value)
  );

endmodule

FILE: sv/msr_checker.sv
// Port-level checks for multisynth_ratio_encoder, attached by bind.
// Depends on msr_pkg.
module msr_checker import msr_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input logic            accepted,
  input logic [2:0]      target,
  input logic [63:0]     reg_bytes,
  input logic [7:0]      clock_control,
  input logic [P1W-1:0]  p1_value,
  input logic [DenW-1:0] p2_value,
  input logic [DenW-1:0] p3_value
);

  // every result strobe traces back to a transaction a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 29))
    else $error("result without matching transaction");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !accepted |-> (target == 3'd0) && (reg_bytes == 64'd0) &&
      (clock_control == 8'd0) && (p1_value == '0) && (p2_value == '0) &&
      (p3_value == '0))
    else $error("rejected result carries data");

  a_pack: assert property (@(posedge clk) disable iff (rst)
    done |-> (reg_bytes[63:48] == p3_value[15:0]) &&
      (reg_bytes[39:24] == p1_value[15:0]) &&
      (reg_bytes[23:20] == p3_value[19:16]) &&
      (reg_bytes[15:0] == p2_value[15:0]))
    else $error("register bytes disagree with P fields");

  a_ctrl: assert property (@(posedge clk) disable iff (rst)
    done && accepted |-> (target <= 3'd4) &&
      ((target >= 3'd2) ? (clock_control[3:0] == CtrlBase) :
                          (clock_control == 8'd0)))
    else $error("clock control inconsistent with target");

endmodule

bind multisynth_ratio_encoder msr_checker u_msr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .accepted      (accepted),
  .target        (target),
  .reg_bytes     (reg_bytes),
  .clock_control (clock_control),
  .p1_value      (p1_value),
  .p2_value      (p2_value),
  .p3_value      (p3_value)
);

FILE: test/testbench.sv
// Self-checking testbench for multisynth_ratio_encoder: directed and random
// divider ratios, R divider code settings and a scoreboard with its own encoder.
// Depends on msr_pkg and the multisynth_ratio_encoder RTL.
module testbench;
  import msr_pkg::*;

  localparam int CycleLimit  = 200000;  // far above the slowest correct run
  localparam int DrainCycles = 40;      // outlasts the pipeline depth
  localparam int PhaseItems  = 285;
  localparam int Phases      = 6;
  localparam logic [1:0] RegUnused = 2'd3;  // no register here, write ignored

  // one command transaction
  typedef struct packed {
    logic            op;
    logic            pll;
    logic [1:0]      port;
    logic [IntW-1:0] a;
    logic [DenW-1:0] b;
    logic [DenW-1:0] c;
  } ratio_cmd_t;

  // one result transaction
  typedef struct packed {
    logic            accepted;
    logic [2:0]      target;
    logic [63:0]     reg_bytes;
    logic [7:0]      clock_control;
    logic [P1W-1:0]  p1;
    logic [DenW-1:0] p2;
    logic [DenW-1:0] p3;
  } ratio_result_t;

  // Holds a copy of the R divider codes and the encodings still in flight.
  class encoding_board;
    ratio_result_t expected_encodings[$];
    logic [2:0]    code_by_port[3];
    int            errors;
    int            commands;
    int            encoded;
    int            rejected;

    function new();
      foreach (code_by_port[i]) code_by_port[i] = '0;
      errors   = 0;
      commands = 0;
      encoded  = 0;
      rejected = 0;
    endfunction

    function void set_code(logic [1:0] index, logic [2:0] value);
      if (index == RegRdiv0) code_by_port[0] = value;
      else if (index == RegRdiv1) code_by_port[1] = value;
      else if (index == RegRdiv2) code_by_port[2] = value;
    endfunction

    function int pending();
      return expected_encodings.size();
    endfunction

    // P1/P2/P3 and register bytes for one ratio, exact integer division
    function ratio_result_t encode_ratio(ratio_cmd_t cmd);
      ratio_result_t res;
      logic          ok;
      logic [63:0]   a_w, b_w, c_w, quot, p1_w, p2_w;
      logic [2:0]    rcode;
      res = '0;
      if (cmd.op == OpPll) ok = (cmd.a >= PllAMin) && (cmd.a <= PllAMax);
      else ok = (cmd.port <= 2'd2) && (cmd.a >= OutAMin) && (cmd.a <= OutAMax);
      if (cmd.c == '0) ok = 1'b0;
      if (!ok) return res;
      a_w = 64'(cmd.a);
      b_w = 64'(cmd.b);
      c_w = 64'(cmd.c);
      if (cmd.op == OpOut && cmd.b != '0 && cmd.c == DenW'(1)) begin
        // output divider, c = 1 with a fraction
        p1_w   = (a_w << FracShift) + (b_w << FracShift) - 64'(P1Offset);
        p2_w   = (b_w << FracShift) - 64'(P2Special);
        res.p3 = DenW'(1);
      end else begin
        quot   = (b_w << FracShift) / c_w;
        p1_w   = (a_w << FracShift) + quot - 64'(P1Offset);
        p2_w   = (b_w << FracShift) - quot * c_w;
        res.p3 = cmd.c;
      end
      res.p1 = p1_w[P1W-1:0];
      res.p2 = p2_w[DenW-1:0];
      rcode  = (cmd.op == OpOut) ? code_by_port[cmd.port] : 3'd0;
      res.accepted  = 1'b1;
      res.reg_bytes = {res.p3[15:8], res.p3[7:0], 1'b0, rcode, 2'b00, res.p1[17:16],
                       res.p1[15:8], res.p1[7:0], res.p3[19:16], res.p2[19:16],
                       res.p2[15:8], res.p2[7:0]};
      if (cmd.op == OpOut) begin
        res.clock_control = {1'b0, cmd.b == '0, cmd.pll, 1'b0, CtrlBase};
        res.target        = 3'd2 + 3'(cmd.port);
      end else begin
        res.clock_control = 8'd0;
        res.target        = {2'b00, cmd.pll};
      end
      return res;
    endfunction

    function void note_command(ratio_cmd_t cmd);
      expected_encodings.push_back(encode_ratio(cmd));
      commands++;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ratio_result_t got);
      ratio_result_t want;
      if (expected_encodings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_encodings.pop_front();
      if (want.accepted) encoded++;
      else rejected++;
      compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
      compare_field("target", 64'(want.target), 64'(got.target));
      compare_field("reg_bytes", want.reg_bytes, got.reg_bytes);
      compare_field("clock_control", 64'(want.clock_control), 64'(got.clock_control));
      compare_field("p1_value", 64'(want.p1), 64'(got.p1));
      compare_field("p2_value", 64'(want.p2), 64'(got.p2));
      compare_field("p3_value", 64'(want.p3), 64'(got.p3));
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst;
  logic            start;
  logic            busy;
  logic            op;
  logic            pll_select;
  logic [1:0]      port;
  logic [IntW-1:0] integer_part;
  logic [DenW-1:0] numerator;
  logic [DenW-1:0] denominator;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [2:0]      cfg_data;
  logic            done;
  logic            accepted;
  logic [2:0]      target;
  logic [63:0]     reg_bytes;
  logic [7:0]      clock_control;
  logic [P1W-1:0]  p1_value;
  logic [DenW-1:0] p2_value;
  logic [DenW-1:0] p3_value;

  encoding_board board = new;
  int            cycles = 0;
  int            settings = 0;

  multisynth_ratio_encoder uut (
    .clk, .rst, .start, .busy, .op, .pll_select, .port, .integer_part,
    .numerator, .denominator, .cfg_we, .cfg_index, .cfg_data, .done,
    .accepted, .target, .reg_bytes, .clock_control, .p1_value, .p2_value,
    .p3_value
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitor: all sampling happens here, at the rising edge, before the
  // block's own flops update. A transaction is taken on start && !busy.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        board.note_command({op, pll_select, port, integer_part, numerator, denominator});
      if (done)
        board.check_result({accepted, target, reg_bytes, clock_control,
                            p1_value, p2_value, p3_value});
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic ratio_cmd_t make_cmd(logic o, logic pl, logic [1:0] pt,
                                          logic [IntW-1:0] a, logic [DenW-1:0] b,
                                          logic [DenW-1:0] c);
    ratio_cmd_t cmd;
    cmd = {o, pl, pt, a, b, c};
    return cmd;
  endfunction

  // Mostly in-range ratios of varied shape; about one in seven gets broken.
  function automatic ratio_cmd_t random_cmd();
    ratio_cmd_t  cmd;
    int unsigned shape;
    cmd.op   = 1'($urandom_range(0, 1));
    cmd.pll  = 1'($urandom_range(0, 1));
    cmd.port = (cmd.op == OpOut) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 3));
    if (cmd.op == OpPll) cmd.a = IntW'($urandom_range(15, 90));
    else if ($urandom_range(0, 9) == 0) cmd.a = $urandom_range(0, 1) ? OutAMax : OutAMin;
    else cmd.a = IntW'($urandom_range(4, 2048));
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1, 2: begin  // small denominator, proper fraction
        cmd.c = DenW'($urandom_range(1, 16));
        cmd.b = DenW'($urandom_range(0, 32'(cmd.c) - 1));
      end
      3, 4, 5: begin  // wide denominator, proper fraction
        cmd.c = DenW'($urandom_range(1, 32'hFFFFF));
        cmd.b = DenW'($urandom % 32'(cmd.c));
      end
      6: begin        // integer mode
        cmd.c = DenW'($urandom_range(1, 32'hFFFFF));
        cmd.b = '0;
      end
      7: begin        // c = 1
        cmd.c = DenW'(1);
        cmd.b = DenW'($urandom);
      end
      8: begin        // b well above c, P1 wraps
        cmd.c = DenW'($urandom_range(1, 255));
        cmd.b = DenW'($urandom);
      end
      default: begin
        cmd.c = DenW'($urandom);
        cmd.b = DenW'($urandom);
      end
    endcase
    if ($urandom_range(0, 6) == 0) begin
      case ($urandom_range(0, 3))
        0: cmd.a = IntW'($urandom);
        1: begin
          cmd.op   = OpOut;
          cmd.port = 2'd3;
        end
        2: cmd.c = '0;
        default: begin
          cmd.op   = 1'($urandom);
          cmd.pll  = 1'($urandom);
          cmd.port = 2'($urandom);
          cmd.a    = IntW'($urandom);
          cmd.b    = DenW'($urandom);
          cmd.c    = DenW'($urandom);
        end
      endcase
    end
    return cmd;
  endfunction

  // Present one transaction, hold it until taken, then maybe idle a burst.
  task automatic send_command(input ratio_cmd_t cmd, input int gap_odds);
    int gap;
    @(negedge clk);
    start        = 1'b1;
    op           = cmd.op;
    pll_select   = cmd.pll;
    port         = cmd.port;
    integer_part = cmd.a;
    numerator    = cmd.b;
    denominator  = cmd.c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap_odds > 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      start        = 1'b0;
      integer_part = IntW'($urandom);  // junk while idle
      numerator    = DenW'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sender holds off until every expected result is back, then the pipe
  // gets a few more cycles to go quiet.
  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [2:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_code(index, value);
  endtask

  task automatic program_codes(input logic [2:0] r0, input logic [2:0] r1,
                               input logic [2:0] r2);
    wait_drained();
    write_reg(RegRdiv0, r0);
    write_reg(RegRdiv1, r1);
    write_reg(RegRdiv2, r2);
    write_reg(RegUnused, 3'($urandom));  // must not disturb the others
    settings++;
  endtask

  initial begin
    int gap_odds;
    start        = 1'b0;
    op           = OpPll;
    pll_select   = 1'b0;
    port         = 2'd0;
    integer_part = '0;
    numerator    = '0;
    denominator  = '0;
    cfg_we       = 1'b0;
    cfg_index    = RegRdiv0;
    cfg_data     = 3'd0;
    rst          = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: range edges, rejects, integer mode, c = 1, P1/P2 wrap
    program_codes(3'd7, 3'd0, 3'd5);
    send_command(make_cmd(OpPll, 1'b0, 2'd0, 12'd15, 20'd0, 20'd1), 4);
    send_command(make_cmd(OpPll, 1'b1, 2'd3, 12'd90, 20'hFFFFF, 20'hFFFFF), 4);
    send_command(make_cmd(OpPll, 1'b0, 2'd0, 12'd14, 20'd5, 20'd9), 4);
    send_command(make_cmd(OpPll, 1'b1, 2'd1, 12'd91, 20'd5, 20'd9), 4);
    send_command(make_cmd(OpPll, 1'b0, 2'd0, 12'd50, 20'd5, 20'd0), 4);
    send_command(make_cmd(OpPll, 1'b0, 2'd2, 12'd90, 20'hFFFFF, 20'd1), 4);
    send_command(make_cmd(OpPll, 1'b1, 2'd0, 12'd4095, 20'd0, 20'hFFFFF), 4);
    send_command(make_cmd(OpPll, 1'b0, 2'd0, 12'd32, 20'd1, 20'hFFFFF), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd0, 12'd4, 20'd0, 20'd1), 4);
    send_command(make_cmd(OpOut, 1'b1, 2'd1, 12'd2048, 20'd1, 20'd1), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd2, 12'd100, 20'hFFFFF, 20'd1), 4);
    send_command(make_cmd(OpOut, 1'b1, 2'd3, 12'd100, 20'd3, 20'd7), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd0, 12'd3, 20'd3, 20'd7), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd1, 12'd2049, 20'd3, 20'd7), 4);
    send_command(make_cmd(OpOut, 1'b1, 2'd2, 12'd4095, 20'd3, 20'd7), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd0, 12'd2048, 20'hFFFFF, 20'd2), 4);
    send_command(make_cmd(OpOut, 1'b1, 2'd1, 12'd0, 20'd0, 20'd0), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd2, 12'd1000, 20'd3, 20'd7), 4);
    send_command(make_cmd(OpOut, 1'b1, 2'd0, 12'd4, 20'hFFFFF, 20'hFFFFF), 4);
    send_command(make_cmd(OpOut, 1'b0, 2'd1, 12'd12, 20'h80000, 20'h80000), 4);

    // random phases, each under its own R divider setting; extremes first,
    // the last phase runs back to back
    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: program_codes(3'd0, 3'd0, 3'd0);
        1: program_codes(3'd7, 3'd7, 3'd7);
        2: program_codes(3'd3, 3'd5, 3'd1);
        default: program_codes(3'($urandom), 3'($urandom), 3'($urandom));
      endcase
      gap_odds = (phase == Phases - 1) ? 0 : 2 + 2 * (phase % 3);
      repeat (PhaseItems) send_command(random_cmd(), gap_odds);
    end

    @(negedge clk);
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d ratio transactions: %0d encoded, %0d rejected.",
             board.commands, board.encoded, board.rejected);
    $display("Covered %0d R divider settings, PLL and output ops, c = 1 and wrap cases.",
             settings);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/msr_pkg.sv
sv/msr_div_cell.sv
sv/msr_pack.sv
sv/multisynth_ratio_encoder.sv
sv/msr_checker.sv
test/testbench.sv
